>>> rtl/tsf_pkg.sv
package tsf_pkg;

    localparam int FUNC_W    = 2;
    localparam int STAMP_W   = 64;
    localparam int STATE_W   = 8;
    localparam int JOINT_W   = 32;
    localparam int IN_JOINTS = 6;
    localparam int CNT_W     = 5;
    localparam int STATUS_W  = 3;
    localparam int MAXD_W    = 5;

    localparam int DEPTH_DEF  = 16;
    localparam int JOINTS_DEF = 6;

    localparam logic [MAXD_W-1:0] MAXD_RESET = 5'd16;

    // Configuration port: one register, so the index is the single word-address bit.
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DEPTH = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH  = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        RS_PUSHED  = 3'd0,
        RS_STALE   = 3'd1,
        RS_ENTRY   = 3'd2,
        RS_EMPTY   = 3'd3,
        RS_CLEARED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_READ_RD,
        S_READ_OUT,
        S_STAT
    } t_state;

    typedef enum logic [1:0] {
        OS_PUSH,
        OS_ENTRY,
        OS_EMPTY,
        OS_CLEAR
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        logic     rd_entry;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_func in_func;
        logic  in_cnt_zero;
        logic  out_free;
        logic  idx_last;
        logic  func_clear;
    } t_dp_stat;

endpackage

>>> rtl/tsf_if.sv
interface tsf_in_if import tsf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [STAMP_W-1:0]   stamp;
    logic [STATE_W-1:0]   run_state;
    logic [JOINT_W-1:0]   joint_0;
    logic [JOINT_W-1:0]   joint_1;
    logic [JOINT_W-1:0]   joint_2;
    logic [JOINT_W-1:0]   joint_3;
    logic [JOINT_W-1:0]   joint_4;
    logic [JOINT_W-1:0]   joint_5;
    logic [CNT_W-1:0]     read_count;
    logic                 remove;

    modport source (
        output valid, func, stamp, run_state,
        output joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
        output read_count, remove,
        input  ready
    );
    modport sink (
        input  valid, func, stamp, run_state,
        input  joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
        input  read_count, remove,
        output ready
    );
endinterface

interface tsf_out_if import tsf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [STAMP_W-1:0]   out_stamp;
    logic [STATE_W-1:0]   out_run_state;
    logic [JOINT_W-1:0]   out_joint_0;
    logic [JOINT_W-1:0]   out_joint_1;
    logic [JOINT_W-1:0]   out_joint_2;
    logic [JOINT_W-1:0]   out_joint_3;
    logic [JOINT_W-1:0]   out_joint_4;
    logic [JOINT_W-1:0]   out_joint_5;
    logic                 last;

    modport source (
        output valid, status, out_stamp, out_run_state,
        output out_joint_0, out_joint_1, out_joint_2, out_joint_3, out_joint_4, out_joint_5,
        output last,
        input  ready
    );
    modport sink (
        input  valid, status, out_stamp, out_run_state,
        input  out_joint_0, out_joint_1, out_joint_2, out_joint_3, out_joint_4, out_joint_5,
        input  last,
        output ready
    );
endinterface

>>> rtl/tsf_regs.sv
module tsf_regs import tsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output logic [MAXD_W-1:0]  o_max_depth
);

    logic [MAXD_W-1:0]    r_max_depth;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1 -: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= MAXD_RESET;
        end else if (wr_en && (reg_idx == REG_MAX_DEPTH)) begin
            r_max_depth <= pwdata[MAXD_W-1:0];
        end
    end

    assign prdata      = (reg_idx == REG_MAX_DEPTH) ? APB_DW'(r_max_depth) : '0;
    assign o_max_depth = r_max_depth;

endmodule

>>> rtl/tsf_ctrl.sv
module tsf_ctrl import tsf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_stat.in_func)
                        FN_PUSH:  n_state = S_PUSH_RD;
                        FN_READ:  n_state = i_stat.in_cnt_zero ? S_STAT : S_READ_RD;
                        FN_CLEAR: n_state = S_STAT;
                        FN_NONE:  n_state = S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH_RD:  n_state = S_PUSH_CMP;
            S_PUSH_CMP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_READ_RD:  n_state = S_READ_OUT;
            S_READ_OUT: begin
                if (i_stat.out_free) n_state = i_stat.idx_last ? S_IDLE : S_READ_RD;
            end
            S_STAT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.rd_entry = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.out_sel  = OS_PUSH;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PUSH_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_PUSH_CMP: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = OS_PUSH;
            end
            S_READ_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_entry = 1'b1;
            end
            S_READ_OUT: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = OS_ENTRY;
            end
            S_STAT: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = i_stat.func_clear ? OS_CLEAR : OS_EMPTY;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/tsf_dp.sv
module tsf_dp import tsf_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int JOINTS = JOINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_dp_cmd                            i_cmd,
    output t_dp_stat                           o_stat,
    input  logic [MAXD_W-1:0]                  i_max_depth,
    input  logic [FUNC_W-1:0]                  i_func,
    input  logic [STAMP_W-1:0]                 i_stamp,
    input  logic [STATE_W-1:0]                 i_run_state,
    input  logic [IN_JOINTS-1:0][JOINT_W-1:0]  i_joint,
    input  logic [CNT_W-1:0]                   i_read_count,
    input  logic                               i_remove,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [STATUS_W-1:0]                o_status,
    output logic [STAMP_W-1:0]                 o_stamp,
    output logic [STATE_W-1:0]                 o_run_state,
    output logic [IN_JOINTS-1:0][JOINT_W-1:0]  o_joint,
    output logic                               o_last
);

    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W   = (OCC_W > MAXD_W) ? OCC_W : MAXD_W;
    localparam int SUM_W   = OCC_W + 1;
    localparam int JBITS   = JOINT_W * JOINTS;
    localparam int WORD_W  = STAMP_W + STATE_W + JBITS;

    // Ring position of an offset from the oldest slot; the sum stays below twice the depth.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [OCC_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
        return sum[IDX_W-1:0];
    endfunction

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    logic [IDX_W-1:0] r_head, n_head;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic [OCC_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;

    t_func                            r_func;
    logic [STAMP_W-1:0]               r_stamp;
    logic [STATE_W-1:0]               r_run_state;
    logic [IN_JOINTS-1:0][JOINT_W-1:0] r_joint;
    logic                             r_remove;
    logic [OCC_W-1:0]                 r_cnt;

    t_status                          r_out_status;
    logic [STAMP_W-1:0]               r_out_stamp;
    logic [STATE_W-1:0]               r_out_run_state;
    logic [IN_JOINTS-1:0][JOINT_W-1:0] r_out_joint;
    logic                             r_out_last;

    t_func            in_func;
    logic [LIM_W-1:0] maxd_ext;
    logic [OCC_W-1:0] lim;
    logic [OCC_W-1:0] drop;
    logic [LIM_W-1:0] req_ext;
    logic [OCC_W-1:0] cnt;
    logic [OCC_W-1:0] newest_off;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_slot;
    logic [WORD_W-1:0] wr_word;
    logic [JBITS-1:0] wr_joints;
    logic [STAMP_W-1:0] rd_stamp;
    logic             stale;
    logic             idx_last;
    logic             mem_we;
    logic [IN_JOINTS-1:0][JOINT_W-1:0] ent_joint;

    assign in_func  = t_func'(i_func);
    assign maxd_ext = LIM_W'(i_max_depth);
    assign req_ext  = LIM_W'(i_read_count);

    always_comb begin
        if (maxd_ext == '0) begin
            lim = OCC_W'(1);
        end else if (maxd_ext > LIM_W'(DEPTH)) begin
            lim = OCC_W'(DEPTH);
        end else begin
            lim = OCC_W'(maxd_ext);
        end
    end

    // When the store is at or above the limit, dropping the oldest entries leaves exactly one below it.
    assign drop = (r_occ >= lim) ? (r_occ - lim + OCC_W'(1)) : '0;
    assign cnt  = ((req_ext == '0) || (req_ext > LIM_W'(r_occ))) ? r_occ
                                                               : OCC_W'(i_read_count);

    assign newest_off = (r_occ == '0) ? '0 : (r_occ - OCC_W'(1));
    assign rd_addr    = i_cmd.rd_entry ? slot_of(r_head, r_idx) : slot_of(r_head, newest_off);
    assign wr_slot    = slot_of(r_head, r_occ);
    assign rd_stamp   = r_rd_data[WORD_W-1 -: STAMP_W];
    assign stale      = (r_occ != '0) && (rd_stamp >= r_stamp);
    assign idx_last   = ((r_idx + OCC_W'(1)) == r_cnt);
    assign mem_we     = i_cmd.out_load && (i_cmd.out_sel == OS_PUSH) && !stale;

    for (genvar j = 0; j < JOINTS; j++) begin : g_wr_joint
        if (j < IN_JOINTS) begin : g_used
            assign wr_joints[j*JOINT_W +: JOINT_W] = r_joint[j];
        end else begin : g_pad
            assign wr_joints[j*JOINT_W +: JOINT_W] = '0;
        end
    end

    for (genvar k = 0; k < IN_JOINTS; k++) begin : g_rd_joint
        if (k < JOINTS) begin : g_used
            assign ent_joint[k] = r_rd_data[k*JOINT_W +: JOINT_W];
        end else begin : g_pad
            assign ent_joint[k] = '0;
        end
    end

    assign wr_word = {r_stamp, r_run_state, wr_joints};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_slot] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_head      = r_head;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.load) begin
            n_idx = '0;
            case (in_func)
                FN_PUSH: begin
                    n_head = slot_of(r_head, drop);
                    n_occ  = r_occ - drop;
                end
                FN_CLEAR: begin
                    n_head = '0;
                    n_occ  = '0;
                end
                default: begin
                    n_head = r_head;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            case (i_cmd.out_sel)
                OS_PUSH: begin
                    if (!stale) n_occ = r_occ + OCC_W'(1);
                end
                OS_ENTRY: begin
                    n_idx = r_idx + OCC_W'(1);
                    if (idx_last && r_remove) begin
                        n_head = slot_of(r_head, r_cnt);
                        n_occ  = r_occ - r_cnt;
                    end
                end
                default: begin
                    n_idx = r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_occ       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= in_func;
            r_stamp     <= i_stamp;
            r_run_state <= i_run_state;
            r_joint     <= i_joint;
            r_remove    <= i_remove;
            r_cnt       <= cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_stamp     <= '0;
            r_out_run_state <= '0;
            r_out_joint     <= '0;
            r_out_last      <= 1'b1;
            case (i_cmd.out_sel)
                OS_PUSH:  r_out_status <= stale ? RS_STALE : RS_PUSHED;
                OS_ENTRY: begin
                    r_out_status    <= RS_ENTRY;
                    r_out_stamp     <= rd_stamp;
                    r_out_run_state <= r_rd_data[JBITS +: STATE_W];
                    r_out_joint     <= ent_joint;
                    r_out_last      <= idx_last;
                end
                OS_EMPTY: r_out_status <= RS_EMPTY;
                OS_CLEAR: r_out_status <= RS_CLEARED;
                default:  r_out_status <= RS_EMPTY;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_stamp     = r_out_stamp;
    assign o_run_state = r_out_run_state;
    assign o_joint     = r_out_joint;
    assign o_last      = r_out_last;

    assign o_stat.in_func     = in_func;
    assign o_stat.in_cnt_zero = (cnt == '0);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_stat.idx_last    = idx_last;
    assign o_stat.func_clear  = (r_func == FN_CLEAR);

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_head) < SUM_W'(DEPTH))
        else $error("head slot outside the ring");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_occ == $past(r_occ) + OCC_W'(1)))
        else $error("stored push did not raise occupancy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while its beat is pending");

endmodule

>>> rtl/timestamped_sample_fifo.sv
// Channel   Dir  Handshake        Beat contents
// i_item    in   valid/ready      func, stamp, run_state, joint_0..5, read_count, remove
// o_result  out  valid/ready      status, out_stamp, out_run_state, out_joint_0..5, last
// apb       in   psel/penable     max_depth at byte address 0, pready tied high
//
// A push steps through accept, read of the newest stamp, then compare and store.
// A read is accepted, then each entry takes a read and an output step, set by the
// single memory read port, registered data; a clear or empty read takes a status step.
// Results wait in one output register; a stalled consumer holds the sequencer.
// Synchronous active-low reset empties the store at once; entries are never cleared.
module timestamped_sample_fifo import tsf_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int JOINTS = JOINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tsf_in_if.sink            i_item,
    tsf_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_dp_cmd                           cmd;
    t_dp_stat                          stat;
    logic [MAXD_W-1:0]                 max_depth;
    logic [IN_JOINTS-1:0][JOINT_W-1:0] item_joint;
    logic [IN_JOINTS-1:0][JOINT_W-1:0] res_joint;

    assign item_joint[0] = i_item.joint_0;
    assign item_joint[1] = i_item.joint_1;
    assign item_joint[2] = i_item.joint_2;
    assign item_joint[3] = i_item.joint_3;
    assign item_joint[4] = i_item.joint_4;
    assign item_joint[5] = i_item.joint_5;

    assign o_result.out_joint_0 = res_joint[0];
    assign o_result.out_joint_1 = res_joint[1];
    assign o_result.out_joint_2 = res_joint[2];
    assign o_result.out_joint_3 = res_joint[3];
    assign o_result.out_joint_4 = res_joint[4];
    assign o_result.out_joint_5 = res_joint[5];

    tsf_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_depth (max_depth)
    );

    tsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (stat),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd)
    );

    tsf_dp #(
        .DEPTH  (DEPTH),
        .JOINTS (JOINTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_max_depth  (max_depth),
        .i_func       (i_item.func),
        .i_stamp      (i_item.stamp),
        .i_run_state  (i_item.run_state),
        .i_joint      (item_joint),
        .i_read_count (i_item.read_count),
        .i_remove     (i_item.remove),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_status     (o_result.status),
        .o_stamp      (o_result.out_stamp),
        .o_run_state  (o_result.out_run_state),
        .o_joint      (res_joint),
        .o_last       (o_result.last)
    );

endmodule
